// ----- rtl/kscl_pkg.sv -----
// Package for the keypad scan code lock: scan state codes, key decode table,
// configuration register indexes and the structs passed between modules.
// No dependencies; every other file imports this package.
package kscl_pkg;

	localparam int KSCL_MAX_LEN = 8;

	localparam int ROW_W      = 4;
	localparam int COL_W      = 3;
	localparam int CHAR_W     = 7;
	localparam int CODE_W     = 64;
	localparam int CODE_LEN_W = 4;
	localparam int CFG_IDX_W  = 4;
	localparam int CODE_MAX   = 8;

	localparam logic [63:0]         CODE_CHARS_RST  = 64'h0000_0023_3130_3031;
	localparam logic [CODE_LEN_W-1:0] CODE_LENGTH_RST = 4'd5;

	localparam logic [CHAR_W-1:0] ENTER_CHAR = 7'h23;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CODE_CHARS  = 4'd0,
		CFG_CODE_LENGTH = 4'd1
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_COL0  = 3'd0,
		ST_COL1  = 3'd1,
		ST_COL2  = 3'd2,
		ST_PRESS = 3'd3,
		ST_WAIT  = 3'd4
	} scan_state_t;

	// Key event from the scanner to the code buffer.
	typedef struct packed {
		logic              press;
		logic [CHAR_W-1:0] key;
	} scan_evt_t;

	// Status from the code buffer back to the result register.
	typedef struct packed {
		logic check_done;
		logic authorized;
	} lock_stat_t;

	// Lowest-numbered active-low row; row 3 when none is low.
	function automatic logic [1:0] lowest_row(input logic [ROW_W-1:0] rows);
		logic [1:0] r;
		priority if (!rows[0]) r = 2'd0;
		else if (!rows[1]) r = 2'd1;
		else if (!rows[2]) r = 2'd2;
		else r = 2'd3;
		return r;
	endfunction

	// ASCII character of the key at a given row and column.
	function automatic logic [CHAR_W-1:0] key_map(input logic [1:0] row, input logic [1:0] col);
		logic [CHAR_W-1:0] k;
		unique case ({row, col})
			4'b00_00: k = 7'h31;
			4'b00_01: k = 7'h32;
			4'b00_10: k = 7'h33;
			4'b01_00: k = 7'h34;
			4'b01_01: k = 7'h35;
			4'b01_10: k = 7'h36;
			4'b10_00: k = 7'h37;
			4'b10_01: k = 7'h38;
			4'b10_10: k = 7'h39;
			4'b11_00: k = 7'h2A;
			4'b11_01: k = 7'h30;
			4'b11_10: k = 7'h23;
			default:  k = 7'h31;
		endcase
		return k;
	endfunction

	// Scan state that drives a given column.
	function automatic scan_state_t col_state(input logic [1:0] col);
		scan_state_t s;
		unique case (col)
			2'd1:    s = ST_COL1;
			2'd2:    s = ST_COL2;
			default: s = ST_COL0;
		endcase
		return s;
	endfunction

endpackage

// ----- rtl/kscl_intf.sv -----
// Valid/ready channel interfaces of the keypad scan code lock: row samples in,
// scan results out, and configuration writes. Depends on kscl_pkg.
interface kscl_in_if
	import kscl_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [ROW_W-1:0] row_lines;
	modport source (output valid, output row_lines, input ready);
	modport sink (input valid, input row_lines, output ready);
endinterface

interface kscl_out_if
	import kscl_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [COL_W-1:0]  col_drive;
	logic              key_valid;
	logic [CHAR_W-1:0] key_char;
	logic              check_done;
	logic              authorized;
	modport source (output valid, output col_drive, output key_valid, output key_char,
		output check_done, output authorized, input ready);
	modport sink (input valid, input col_drive, input key_valid, input key_char,
		input check_done, input authorized, output ready);
endinterface

interface kscl_cfg_if
	import kscl_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] reg_index;
	logic [CODE_W-1:0]    wdata;
	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

// ----- rtl/kscl_scan.sv -----
// Column scan state machine of the keypad scan code lock: column drive,
// pressed column and key decode. Depends on kscl_pkg.
module kscl_scan
	import kscl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic [ROW_W-1:0] row_lines,
	output logic [COL_W-1:0] col_drive,
	output scan_evt_t        evt
);

	scan_state_t state_q, state_d;
	logic [1:0]  pcol_q, pcol_d;
	logic        any_row;
	logic [1:0]  key_col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COL0;
			pcol_q  <= 2'd0;
		end else if (advance) begin
			state_q <= state_d;
			pcol_q  <= pcol_d;
		end
	end

	always_comb begin
		any_row = (row_lines != {ROW_W{1'b1}});
		state_d = state_q;
		pcol_d  = pcol_q;
		unique case (state_q)
			ST_COL0, ST_COL1, ST_COL2: begin
				if (any_row) begin
					pcol_d  = state_q[1:0];
					state_d = ST_PRESS;
				end else begin
					state_d = (state_q == ST_COL2) ? ST_COL0 : col_state(state_q[1:0] + 2'd1);
				end
			end
			ST_PRESS: state_d = ST_WAIT;
			ST_WAIT: begin
				if (!any_row) begin
					state_d = (pcol_q < 2'd2) ? col_state(pcol_q + 2'd1) : ST_COL0;
				end
			end
			default: state_d = ST_COL0;
		endcase

		// The recorded column stays driven low while pressed or waiting.
		if (state_d == ST_COL0 || state_d == ST_COL1 || state_d == ST_COL2) begin
			col_drive = ~(COL_W'(1) << state_d[1:0]);
		end else if (pcol_d < 2'd3) begin
			col_drive = ~(COL_W'(1) << pcol_d);
		end else begin
			col_drive = '0;
		end

		key_col   = (pcol_d < 2'd3) ? pcol_d : 2'd0;
		evt.press = (state_d == ST_PRESS);
		evt.key   = evt.press ? key_map(lowest_row(row_lines), key_col) : '0;
	end

endmodule

// ----- rtl/kscl_codebuf.sv -----
// Code buffer of the keypad scan code lock: key append, overflow tracking,
// code comparison on the enter key and the authorization flag. Depends on kscl_pkg.
module kscl_codebuf
	import kscl_pkg::*;
#(
	parameter int MAX_LEN = KSCL_MAX_LEN
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  scan_evt_t             evt,
	input  logic [CODE_W-1:0]     code_chars,
	input  logic [CODE_LEN_W-1:0] code_length,
	output lock_stat_t            stat
);

	localparam int CW   = $clog2(MAX_LEN + 1);
	localparam int IW   = $clog2(MAX_LEN);
	localparam int LW   = (CW > CODE_LEN_W) ? CW : CODE_LEN_W;
	localparam int NCMP = (MAX_LEN < CODE_MAX) ? MAX_LEN : CODE_MAX;

	logic [CHAR_W-1:0] buf_q [MAX_LEN];
	logic [CW-1:0]     count_q, count_app;
	logic              ovf_q, ovf_app;
	logic              auth_q;
	logic              full, is_enter, match, chars_ok;
	logic [CHAR_W-1:0] ch;

	always_comb begin
		full      = (count_q == CW'(MAX_LEN));
		count_app = full ? count_q : count_q + CW'(1);
		ovf_app   = ovf_q | full;
		is_enter  = (evt.key == ENTER_CHAR);

		// Entries at or past the count are never looked at; the new key is
		// taken straight from the event when it lands in this cycle.
		chars_ok = 1'b1;
		for (int i = 0; i < NCMP; i++) begin
			ch = (!full && count_q == CW'(i)) ? evt.key : buf_q[i];
			if (CW'(i) < count_app && {1'b0, ch} != code_chars[8*i +: 8]) begin
				chars_ok = 1'b0;
			end
		end

		match = !ovf_app && (code_length <= CODE_LEN_W'(CODE_MAX)) &&
			(LW'(count_app) == LW'(code_length)) && chars_ok;

		stat.check_done = evt.press && is_enter;
		stat.authorized = stat.check_done ? match : auth_q;
	end

	always_ff @(posedge clk) begin
		if (advance && evt.press && !full) begin
			buf_q[count_q[IW-1:0]] <= evt.key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			auth_q  <= 1'b0;
		end else if (advance && evt.press) begin
			if (is_enter) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
				auth_q  <= match;
			end else begin
				count_q <= count_app;
				ovf_q   <= ovf_app;
			end
		end
	end

endmodule

// ----- rtl/keypad_scan_code_lock.sv -----
// Top level of the keypad scan code lock: configuration registers, handshake
// and result register. Depends on kscl_pkg, kscl_intf, kscl_scan, kscl_codebuf.
//
// Usage: every transfer on the scan channel is one scan tick carrying the four
// sampled active-low row lines. Each tick produces exactly one transfer on the
// result channel with the column drive to apply, the decoded key (when a key
// was recognized on that tick), a flag for a code check triggered by '#', and
// the current authorization flag.
// The result of a tick is in the result register on the cycle after its transfer.
// One tick per cycle while the receiver takes every result; the whole step is
// the scan state machine plus an eight-character parallel compare, both done
// between the state registers and the result register.
// When the receiver stalls, the result register holds its contents and the
// scan channel stays ready only if the pending result is taken in that cycle.
// The configuration channel is always ready; index 0 writes the expected code
// characters (first in the lowest byte), index 1 the code length including the
// '#', and other indexes are ignored. Writes belong in idle periods.
// Reset clears the scan state to column zero, empties the code buffer, clears
// the authorization flag and reloads the code "1001#" with length 5. The
// buffer entries themselves are not cleared; only written entries are read.
module keypad_scan_code_lock
	import kscl_pkg::*;
#(
	parameter int MAX_LEN = KSCL_MAX_LEN
) (
	input  logic        clk,
	input  logic        arst_n,
	kscl_in_if.sink     scan,
	kscl_out_if.source  result,
	kscl_cfg_if.sink    cfg
);

	logic [CODE_W-1:0]     code_chars_q;
	logic [CODE_LEN_W-1:0] code_length_q;

	logic              accept;
	logic [COL_W-1:0]  col_drive;
	scan_evt_t         evt;
	lock_stat_t        stat;

	logic              out_valid_q;
	logic [COL_W-1:0]  col_drive_q;
	logic              key_valid_q;
	logic [CHAR_W-1:0] key_char_q;
	logic              check_done_q;
	logic              authorized_q;

	// Configuration writes complete in the cycle they are presented.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_chars_q  <= CODE_CHARS_RST;
			code_length_q <= CODE_LENGTH_RST;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				CFG_CODE_CHARS:  code_chars_q  <= cfg.wdata;
				CFG_CODE_LENGTH: code_length_q <= cfg.wdata[CODE_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// A new tick is taken whenever the result register is empty or is being
	// emptied in this cycle.
	assign scan.ready = !out_valid_q || result.ready;
	assign accept     = scan.valid && scan.ready;

	kscl_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (accept),
		.row_lines (scan.row_lines),
		.col_drive (col_drive),
		.evt       (evt)
	);

	kscl_codebuf #(
		.MAX_LEN (MAX_LEN)
	) u_codebuf (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (accept),
		.evt         (evt),
		.code_chars  (code_chars_q),
		.code_length (code_length_q),
		.stat        (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_drive_q  <= col_drive;
			key_valid_q  <= evt.press;
			key_char_q   <= evt.key;
			check_done_q <= stat.check_done;
			authorized_q <= stat.authorized;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.col_drive  = col_drive_q;
	assign result.key_valid  = key_valid_q;
	assign result.key_char   = key_char_q;
	assign result.check_done = check_done_q;
	assign result.authorized = authorized_q;

endmodule
